// ===== design/afhc_pkg.sv =====
// ----------------------------------------------------------------------------
// afhc_pkg
// Shared types, codes and constant tables for the audio frame header checker.
// ----------------------------------------------------------------------------
package afhc_pkg;

    // stream kind codes on the result channel
    localparam logic [1:0] KIND_AC3  = 2'd0;
    localparam logic [1:0] KIND_MPEG = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    // sync bytes
    localparam logic [7:0] SYNC_AC3_HI  = 8'h0B;
    localparam logic [7:0] SYNC_AC3_LO  = 8'h77;
    localparam logic [7:0] SYNC_MPEG_HI = 8'hFF;

    // field values, reserved codes among them
    localparam logic [5:0] AC3_CODES      = 6'd38;
    localparam logic [1:0] AC3_FS_RSVD    = 2'd3;
    localparam logic [1:0] MPEG_VER_RSVD  = 2'd1;
    localparam logic [1:0] MPEG_VER_1     = 2'd3;
    localparam logic [1:0] MPEG_VER_2     = 2'd2;
    localparam logic [1:0] MPEG_VER_25    = 2'd0;
    localparam logic [1:0] MPEG_LAY_RSVD  = 2'd0;
    localparam logic [3:0] MPEG_BR_FREE   = 4'd0;
    localparam logic [3:0] MPEG_BR_BAD    = 4'hF;
    localparam logic [1:0] MPEG_SR_RSVD   = 2'd3;
    localparam logic [1:0] MPEG_SR_11K    = 2'd0;
    localparam logic [1:0] MPEG_SR_12K    = 2'd1;
    localparam logic [1:0] MPEG_SR_8K     = 2'd2;
    localparam logic [1:0] MPEG_EMPH_RSVD = 2'd2;

    // slots per frame
    localparam logic [7:0] SLOTS_L1   = 8'd12;
    localparam logic [7:0] SLOTS_FULL = 8'd144;
    localparam logic [7:0] SLOTS_HALF = 8'd72;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // reciprocal multipliers, quotient taken from product bit RECIP_SHIFT up
    // kbps*1000/11025 = kbps*40/441, kbps*1000/12000 = kbps/12, /8000 = kbps/8
    localparam int RECIP_SHIFT = 30;
    localparam logic [27:0] RECIP_441 =
        28'(((64'd1 << RECIP_SHIFT) + 64'd440) / 64'd441);
    localparam logic [27:0] RECIP_12 =
        28'(((64'd1 << RECIP_SHIFT) + 64'd11) / 64'd12);
    localparam logic [27:0] RECIP_8 = 28'(64'd1 << (RECIP_SHIFT - 3));

    // one classified header on its way to the back part
    typedef struct packed {
        logic        hdr_ok;
        logic [1:0]  kind;
        logic [11:0] bytes;     // final length when use_calc is low
        logic        use_calc;  // mpeg length still to be computed
        logic [15:0] slot_kbps; // slots times kbit/s
        logic [1:0]  sri;
        logic [1:0]  fam_sh;    // right shift for the version's rate multiple
        logic        pad;
        logic        layer1;
    } t_item;

    // ac-3 words per syncframe by fscod and frmsizecod
    localparam logic [10:0] AC3_WORDS [0:2][0:37] = '{
        '{11'd64, 11'd64, 11'd80, 11'd80, 11'd96, 11'd96, 11'd112, 11'd112,
          11'd128, 11'd128, 11'd160, 11'd160, 11'd192, 11'd192, 11'd224, 11'd224,
          11'd256, 11'd256, 11'd320, 11'd320, 11'd384, 11'd384, 11'd448, 11'd448,
          11'd512, 11'd512, 11'd640, 11'd640, 11'd768, 11'd768, 11'd896, 11'd896,
          11'd1024, 11'd1024, 11'd1152, 11'd1152, 11'd1280, 11'd1280},
        '{11'd69, 11'd70, 11'd87, 11'd88, 11'd104, 11'd105, 11'd121, 11'd122,
          11'd139, 11'd140, 11'd174, 11'd175, 11'd208, 11'd209, 11'd243, 11'd244,
          11'd278, 11'd279, 11'd348, 11'd349, 11'd417, 11'd418, 11'd487, 11'd488,
          11'd557, 11'd558, 11'd696, 11'd697, 11'd835, 11'd836, 11'd975, 11'd976,
          11'd1114, 11'd1115, 11'd1253, 11'd1254, 11'd1393, 11'd1394},
        '{11'd96, 11'd96, 11'd120, 11'd120, 11'd144, 11'd144, 11'd168, 11'd168,
          11'd192, 11'd192, 11'd240, 11'd240, 11'd288, 11'd288, 11'd336, 11'd336,
          11'd384, 11'd384, 11'd480, 11'd480, 11'd576, 11'd576, 11'd672, 11'd672,
          11'd768, 11'd768, 11'd960, 11'd960, 11'd1152, 11'd1152, 11'd1344, 11'd1344,
          11'd1536, 11'd1536, 11'd1728, 11'd1728, 11'd1920, 11'd1920}
    };

    // mpeg bitrates in kbit/s by family, layer (I..III) and index
    localparam logic [8:0] MPEG_KBPS [0:1][0:2][0:15] = '{
        '{
            '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
              9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
            '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
              9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
            '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
              9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
        },
        '{
            '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
              9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
            '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
              9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
            '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
              9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
        }
    };

endpackage

// ===== design/afhc_front.sv =====
// ----------------------------------------------------------------------------
// afhc_front
// Accepts a header word, checks sync and reserved fields, and registers the
// classified item until the queue takes it.
// ----------------------------------------------------------------------------
module afhc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [39:0]         i_header_word,
    input  logic                i_q_full,
    output logic                o_busy,
    output logic                o_push,
    output afhc_pkg::t_item     o_item
);

    logic              r_valid;
    afhc_pkg::t_item   r_item;
    afhc_pkg::t_item   n_item;
    logic              w_accept;
    logic              w_load_ok;

    logic [7:0]  b0;
    logic [7:0]  b1;
    logic        ac3_sync;
    logic        mpeg_sync;
    logic [1:0]  fs;
    logic [5:0]  code;
    logic        ac3_ok;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [3:0]  bri;
    logic [1:0]  sri;
    logic [1:0]  emph;
    logic [1:0]  li;
    logic        fam;
    logic        mpeg_ok;
    logic [8:0]  kbps;
    logic [7:0]  slots;
    logic [16:0] slot_prod;

    // handshake
    assign o_push    = r_valid && !i_q_full;
    assign w_load_ok = !r_valid || o_push;
    assign o_busy    = !w_load_ok;
    assign w_accept  = i_start && w_load_ok;
    assign o_item    = r_item;

    // field extraction
    assign b0   = i_header_word[39:32];
    assign b1   = i_header_word[31:24];
    assign fs   = i_header_word[7:6];
    assign code = i_header_word[5:0];
    assign ver  = i_header_word[28:27];
    assign lay  = i_header_word[26:25];
    assign bri  = i_header_word[23:20];
    assign sri  = i_header_word[19:18];
    assign emph = i_header_word[9:8];

    assign ac3_sync  = (b0 == afhc_pkg::SYNC_AC3_HI) && (b1 == afhc_pkg::SYNC_AC3_LO);
    assign mpeg_sync = (b0 == afhc_pkg::SYNC_MPEG_HI) && (b1[7:5] == 3'b111);

    assign ac3_ok  = (fs != afhc_pkg::AC3_FS_RSVD) && (code < afhc_pkg::AC3_CODES);
    assign mpeg_ok = (ver != afhc_pkg::MPEG_VER_RSVD) && (lay != afhc_pkg::MPEG_LAY_RSVD)
                  && (bri != afhc_pkg::MPEG_BR_BAD) && (sri != afhc_pkg::MPEG_SR_RSVD)
                  && (emph != afhc_pkg::MPEG_EMPH_RSVD);

    // layer I is index 0; reserved layer code maps to 0 and is rejected anyway
    assign li  = (lay == afhc_pkg::MPEG_LAY_RSVD) ? 2'd0 : 2'(2'd3 - lay);
    assign fam = (ver != afhc_pkg::MPEG_VER_1);

    // bitrate and slot count
    always_comb begin
        kbps = afhc_pkg::MPEG_KBPS[fam][li][bri];
        if (li == 2'd0) begin
            slots = afhc_pkg::SLOTS_L1;
        end else if (li == 2'd1 || !fam) begin
            slots = afhc_pkg::SLOTS_FULL;
        end else begin
            slots = afhc_pkg::SLOTS_HALF;
        end
        slot_prod = 17'(slots) * 17'(kbps);
    end

    // classified item
    always_comb begin
        n_item           = '0;
        n_item.kind      = afhc_pkg::KIND_NONE;
        n_item.slot_kbps = slot_prod[15:0];
        n_item.sri       = sri;
        n_item.pad       = i_header_word[17];
        n_item.layer1    = (li == 2'd0);
        case (ver)
            afhc_pkg::MPEG_VER_1: n_item.fam_sh = 2'd2;
            afhc_pkg::MPEG_VER_2: n_item.fam_sh = 2'd1;
            default:              n_item.fam_sh = 2'd0;
        endcase
        if (ac3_sync) begin
            n_item.kind = afhc_pkg::KIND_AC3;
            if (ac3_ok) begin
                n_item.hdr_ok = 1'b1;
                n_item.bytes  = {afhc_pkg::AC3_WORDS[fs][code], 1'b0};
            end
        end else if (mpeg_sync) begin
            n_item.kind = afhc_pkg::KIND_MPEG;
            if (mpeg_ok) begin
                n_item.hdr_ok   = 1'b1;
                n_item.use_calc = (bri != afhc_pkg::MPEG_BR_FREE);
            end
        end
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load_ok) begin
            r_valid <= i_start;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== design/afhc_fifo.sv =====
// ----------------------------------------------------------------------------
// afhc_fifo
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module afhc_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  afhc_pkg::t_item     i_item,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output afhc_pkg::t_item     o_item
);

    afhc_pkg::t_item                 r_slot [afhc_pkg::Q_DEPTH];
    logic [afhc_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [afhc_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [afhc_pkg::Q_CNT_W-1:0]    r_count;
    logic                            w_push;
    logic                            w_pop;

    assign o_full  = (r_count == afhc_pkg::Q_CNT_W'(afhc_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_item  = r_slot[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == afhc_pkg::Q_PTR_W'(afhc_pkg::Q_DEPTH - 1))
                          ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == afhc_pkg::Q_PTR_W'(afhc_pkg::Q_DEPTH - 1))
                          ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== design/afhc_back.sv =====
// ----------------------------------------------------------------------------
// afhc_back
// Computes the mpeg frame length by reciprocal multiply and drives the
// registered result with its strobe.
// ----------------------------------------------------------------------------
module afhc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  afhc_pkg::t_item     i_item,
    output logic                o_done,
    output logic                o_header_ok,
    output logic [1:0]          o_stream_kind,
    output logic [11:0]         o_frame_bytes
);

    logic              r_b1_valid;
    afhc_pkg::t_item   r_b1_item;
    logic [49:0]       r_prod;
    logic [49:0]       n_prod;
    logic [21:0]       w_num;
    logic [27:0]       w_recip;

    logic              r_done;
    logic              r_header_ok;
    logic [1:0]        r_stream_kind;
    logic [11:0]       r_frame_bytes;
    logic [12:0]       w_quot;
    logic [12:0]       w_slots;
    logic [12:0]       w_slots_pad;
    logic [11:0]       n_frame_bytes;

    // numerator and reciprocal chosen by sample-rate index
    always_comb begin
        case (i_item.sri)
            afhc_pkg::MPEG_SR_11K: begin
                w_num   = 22'({i_item.slot_kbps, 5'b0}) + 22'({i_item.slot_kbps, 3'b0});
                w_recip = afhc_pkg::RECIP_441;
            end
            afhc_pkg::MPEG_SR_12K: begin
                w_num   = 22'(i_item.slot_kbps);
                w_recip = afhc_pkg::RECIP_12;
            end
            afhc_pkg::MPEG_SR_8K: begin
                w_num   = 22'(i_item.slot_kbps);
                w_recip = afhc_pkg::RECIP_8;
            end
            default: begin
                w_num   = '0;
                w_recip = '0;
            end
        endcase
        n_prod = {28'd0, w_num} * {22'd0, w_recip};
    end

    // stage one: multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else begin
            r_b1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_b1_item <= i_item;
            r_prod    <= n_prod;
        end
    end

    // stage two: scale by version, add padding, apply slot size
    always_comb begin
        w_quot      = r_prod[afhc_pkg::RECIP_SHIFT+12:afhc_pkg::RECIP_SHIFT];
        w_slots     = w_quot >> r_b1_item.fam_sh;
        w_slots_pad = w_slots + 13'(r_b1_item.pad);
        if (!r_b1_item.use_calc) begin
            n_frame_bytes = r_b1_item.bytes;
        end else if (r_b1_item.layer1) begin
            n_frame_bytes = {w_slots_pad[9:0], 2'b00};
        end else begin
            n_frame_bytes = w_slots_pad[11:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b1_valid) begin
            r_header_ok   <= r_b1_item.hdr_ok;
            r_stream_kind <= r_b1_item.kind;
            r_frame_bytes <= n_frame_bytes;
        end
    end

    assign o_done        = r_done;
    assign o_header_ok   = r_header_ok;
    assign o_stream_kind = r_stream_kind;
    assign o_frame_bytes = r_frame_bytes;

    // a nonzero length only comes with an accepted header
    a_len_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_frame_bytes != 12'd0) |-> r_header_ok)
        else $error("frame length given for a rejected header");

    // an accepted header always names a sync
    a_ok_has_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_header_ok) |-> (r_stream_kind != afhc_pkg::KIND_NONE))
        else $error("accepted header without sync");

    // results follow the multiply stage in the next cycle
    a_stage_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b1_valid |=> r_done)
        else $error("result strobe missing after multiply stage");

endmodule

// ===== design/audio_frame_header_checker_unit.sv =====
// ----------------------------------------------------------------------------
// audio_frame_header_checker_unit
// Checks a five-byte AC-3 or MPEG audio header and gives its frame length.
// ----------------------------------------------------------------------------
// Usage:
//   input  : raise start with the 40-bit header on i_header_word (first byte
//            in bits 39..32); the transfer happens at a rising edge where start
//            is high and busy is low.
//   output : o_done is high for exactly one cycle with o_header_ok,
//            o_stream_kind and o_frame_bytes; the transfer happens at the edge
//            that ends that cycle, and the receiver cannot hold it off.
//   path   : from its input transfer a header passes the front register,
//            the queue, the multiply stage and the result register.
//   rate   : one header per cycle; the back part never stalls, so the
//            two-entry queue never fills and busy stays low.
//   length : MPEG lengths use one 22x28 reciprocal multiply per header in
//            the back part; AC-3 lengths come from a constant table in front.
//   reset  : synchronous, active low; clears the front, queue and result
//            strobes, so items in flight are dropped.
// ----------------------------------------------------------------------------
module audio_frame_header_checker_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [39:0]  i_header_word,
    output logic         o_done,
    output logic         o_header_ok,
    output logic [1:0]   o_stream_kind,
    output logic [11:0]  o_frame_bytes
);

    afhc_pkg::t_item   w_front_item;
    afhc_pkg::t_item   w_q_item;
    logic              w_push;
    logic              w_q_full;
    logic              w_q_empty;
    logic              w_pop;

    // front part: classify and hold
    afhc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_header_word  (i_header_word),
        .i_q_full       (w_q_full),
        .o_busy         (busy),
        .o_push         (w_push),
        .o_item         (w_front_item)
    );

    // queue between the parts
    afhc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_front_item),
        .i_pop    (w_pop),
        .o_full   (w_q_full),
        .o_empty  (w_q_empty),
        .o_item   (w_q_item)
    );

    // back part takes an item whenever one is queued
    assign w_pop = !w_q_empty;

    afhc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_pop),
        .i_item         (w_q_item),
        .o_done         (o_done),
        .o_header_ok    (o_header_ok),
        .o_stream_kind  (o_stream_kind),
        .o_frame_bytes  (o_frame_bytes)
    );

    // fixed latency from input transfer to result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_done)
        else $error("result strobe missing four cycles after transfer");

    // the back part drains the queue every cycle, so it never fills
    a_never_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_q_full)
        else $error("queue filled up");

    // no strobe without an earlier transfer
    a_done_has_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_pop, 2))
        else $error("result strobe without queued item");

endmodule
